@@ rtl/core/qli_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qli_pkg;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_P0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P2_Y = 3'd5;

  localparam int NPTS = 3;                       // control points held
  localparam int QW = 96;                        // quotient bits of one scale step
  localparam int BITS_PER_STG = 4;               // quotient bits per divider stage
  localparam int DIV_STG = QW / BITS_PER_STG;
  localparam int STEP_LAT = DIV_STG + 5;         // prep, two multiply, divide, two round
  localparam logic [60:0] ACC_LIM = {61{1'b1}};  // 2^61 - 1

  typedef struct packed {
    logic [NPTS-1:0][31:0]            px;
    logic [NPTS-1:0][31:0]            py;
    logic [NPTS-1:0][NPTS-1:0][32:0]  dmag;
    logic [NPTS-1:0][NPTS-1:0]        dneg;
    logic                             degen;
  } cfg_t;

  typedef struct packed {
    logic [31:0] x;
    logic        neg;
    logic        sat;
  } sb_t;

  typedef struct packed {
    logic [31:0] y;
    logic        sat;
    logic        deg;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/qli_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qli_cfg #(
  parameter int P = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [qli_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [31:0]                     data_i,
  output qli_pkg::cfg_t                   cfg_o
);
  import qli_pkg::*;

  logic [NPTS-1:0][31:0]           px_q, py_q;
  logic [NPTS-1:0][NPTS-1:0][32:0] dmag_d, dmag_q;
  logic [NPTS-1:0][NPTS-1:0]       dneg_d, dneg_q;
  logic                            degen_d, degen_q;
  logic [NPTS-1:0][NPTS-1:0][32:0] diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q[0] <= 32'h0000_0000;
      px_q[1] <= 32'h0001_0000;
      px_q[2] <= 32'h0002_0000;
      py_q    <= '0;
    end else if (we_i) begin
      case (idx_i)
        REG_P0_X: px_q[0] <= data_i;
        REG_P0_Y: py_q[0] <= data_i;
        REG_P1_X: px_q[1] <= data_i;
        REG_P1_Y: py_q[1] <= data_i;
        REG_P2_X: px_q[2] <= data_i;
        REG_P2_Y: py_q[2] <= data_i;
        default: ;
      endcase
    end
  end

  // denominators x_i - x_j, kept as magnitude and sign
  always_comb begin
    degen_d = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      for (int j = 0; j < NPTS; j++) begin
        diff[i][j]   = {px_q[i][31], px_q[i]} - {px_q[j][31], px_q[j]};
        dneg_d[i][j] = diff[i][j][32];
        dmag_d[i][j] = diff[i][j][32] ? (~diff[i][j] + 33'd1) : diff[i][j];
        if (i < P && j < P && i < j && px_q[i] == px_q[j]) begin
          degen_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q  <= dmag_d;
    dneg_q  <= dneg_d;
    degen_q <= degen_d;
  end

  assign cfg_o.px    = px_q;
  assign cfg_o.py    = py_q;
  assign cfg_o.dmag  = dmag_q;
  assign cfg_o.dneg  = dneg_q;
  assign cfg_o.degen = degen_q;

endmodule
`default_nettype wire

@@ rtl/core/qli_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qli_step (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] acc_i,
  input  logic [31:0] x_i,
  input  logic [31:0] xj_i,
  input  logic [32:0] dmag_i,
  input  logic        dneg_i,
  input  logic        sat_i,
  output logic [63:0] acc_o,
  output logic [31:0] x_o,
  output logic        sat_o
);
  import qli_pkg::*;

  // prep: numerator and magnitudes
  logic [32:0] num, num_mag;
  logic [63:0] acc_abs;
  logic [61:0] a_mag_q;
  logic [32:0] n_mag_q;
  sb_t         sb0_q, sb1_q;
  logic [63:0] pl_q, ph_q;
  logic [QW-1:0] dd_q [DIV_STG+1];
  logic [32:0]   dr_q [DIV_STG+1];
  sb_t           sbd_q [DIV_STG+1];
  logic [QW-1:0] qr_q;
  sb_t           sbr_q;
  logic          up, big;
  logic [63:0]   mag;

  always_comb begin
    num     = {x_i[31], x_i} - {xj_i[31], xj_i};
    num_mag = num[32] ? (~num + 33'd1) : num;
    acc_abs = acc_i[63] ? (~acc_i + 64'd1) : acc_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q   <= acc_abs[61:0];
      n_mag_q   <= num_mag;
      sb0_q.x   <= x_i;
      sb0_q.neg <= acc_i[63] ^ num[32] ^ dneg_i;
      sb0_q.sat <= sat_i;
    end
  end

  // two partial products, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q  <= {33'b0, a_mag_q[30:0]} * {31'b0, n_mag_q};
      ph_q  <= {33'b0, a_mag_q[61:31]} * {31'b0, n_mag_q};
      sb1_q <= sb0_q;
      dd_q[0]  <= {1'b0, ph_q[63:0], 31'b0} + {32'b0, pl_q};
      dr_q[0]  <= '0;
      sbd_q[0] <= sb1_q;
    end
  end

  // restoring long division, quotient bits shift into the dividend word
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    logic [32:0]   r_d;
    logic [QW-1:0] d_d;
    logic [33:0]   t;
    always_comb begin
      r_d = dr_q[s];
      d_d = dd_q[s];
      t   = '0;
      for (int b = 0; b < BITS_PER_STG; b++) begin
        t   = {r_d, d_d[QW-1]};
        d_d = {d_d[QW-2:0], 1'b0};
        if (t >= {1'b0, dmag_i}) begin
          t      = t - {1'b0, dmag_i};
          d_d[0] = 1'b1;
        end
        r_d = t[32:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[s+1]  <= r_d;
        dd_q[s+1]  <= d_d;
        sbd_q[s+1] <= sbd_q[s];
      end
    end
  end

  // round half away from zero, then clamp and apply sign
  assign up  = {dr_q[DIV_STG], 1'b0} >= {1'b0, dmag_i};
  assign big = |qr_q[QW-1:61];
  assign mag = big ? {3'b0, ACC_LIM} : {3'b0, qr_q[60:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr_q  <= dd_q[DIV_STG] + {{(QW-1){1'b0}}, up};
      sbr_q <= sbd_q[DIV_STG];
      acc_o <= sbr_q.neg ? (~mag + 64'd1) : mag;
      x_o   <= sbr_q.x;
      sat_o <= sbr_q.sat | big;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/quadratic_lagrange_interpolator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// quadratic lagrange interpolator
// evaluates at sample_x the polynomial through the configured control points
// (all values signed q16.16), result saturated to the 32-bit range
// input channel: in_valid_i / in_stall_o with sample_x_i, one word per cycle
// output channel: out_valid_o / out_stall_i with curve_y_o, saturated_o and
// degenerate_o, one word per input word, in order
// configuration: cfg_we_i writes cfg_data_i to point register cfg_idx_i
// (0..5 = x0 y0 x1 y1 x2 y2); the user writes only while no word is in
// flight, which the block does not enforce
// steps: each scale step is a 29-stage pipe set by its 96-bit long division
// at four quotient bits per stage
// throughput: one word per cycle unless stalled, whole pipe on one enable
// stall: the output register plus one skid word absorb a stall; in_stall_o
// rises only once the skid word is occupied, nothing is lost or repeated
// reset: points go to (0,0) (1,0) (2,0), pipe and output empty
module quadratic_lagrange_interpolator_unit #(
  parameter int NUM_POINTS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [31:0]                     sample_x_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     curve_y_o,
  output logic                            saturated_o,
  output logic                            degenerate_o,
  input  logic                            cfg_we_i,
  input  logic [qli_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);
  import qli_pkg::*;

  // points actually used, two or three
  localparam int P = (NUM_POINTS < 2) ? 2 : ((NUM_POINTS > NPTS) ? NPTS : NUM_POINTS);
  localparam int CHAIN = (P - 1) * STEP_LAT;
  localparam int LAT = CHAIN + 3;

  cfg_t cfg;
  logic adv;
  logic [LAT-1:0] vld_q;
  logic [31:0] x_q;

  logic [63:0] acc_w [P][P];
  logic [31:0] x_w   [P][P];
  logic        sat_w [P][P];

  logic signed [63:0] sum_d, sum_q;
  logic               ssat_d, ssat_q;
  logic [63:0]        sum_abs, rnd;
  logic [47:0]        m_q;
  logic               mneg_q, msat_q;
  res_t               pipe_res;
  res_t               out_q, skid_q;
  logic               out_valid_q, skid_full_q;

  qli_cfg #(.P(P)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // the whole pipe advances unless the skid word is held
  assign adv        = !skid_full_q;
  assign in_stall_o = skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= sample_x_i;
    end
  end

  // one chain of scale steps per term, other points in ascending order
  for (genvar i = 0; i < P; i++) begin : g_term
    assign acc_w[i][0] = {{16{cfg.py[i][31]}}, cfg.py[i], 16'b0};
    assign x_w[i][0]   = x_q;
    assign sat_w[i][0] = 1'b0;
    for (genvar k = 0; k < P - 1; k++) begin : g_step
      localparam int J = (k < i) ? k : k + 1;
      qli_step u_step (
        .clk_i  (clk_i),
        .en_i   (adv),
        .acc_i  (acc_w[i][k]),
        .x_i    (x_w[i][k]),
        .xj_i   (cfg.px[J]),
        .dmag_i (cfg.dmag[i][J]),
        .dneg_i (cfg.dneg[i][J]),
        .sat_i  (sat_w[i][k]),
        .acc_o  (acc_w[i][k+1]),
        .x_o    (x_w[i][k+1]),
        .sat_o  (sat_w[i][k+1])
      );
    end
  end

  // sum of terms
  always_comb begin
    sum_d  = '0;
    ssat_d = 1'b0;
    for (int i = 0; i < P; i++) begin
      sum_d  = sum_d + $signed(acc_w[i][P-1]);
      ssat_d = ssat_d | sat_w[i][P-1];
    end
  end

  // back to q16.16 with round half away from zero
  assign sum_abs = sum_q[63] ? (~sum_q + 64'd1) : sum_q;
  assign rnd     = sum_abs + 64'h8000;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q  <= sum_d;
      ssat_q <= ssat_d;
      m_q    <= rnd[63:16];
      mneg_q <= sum_q[63];
      msat_q <= ssat_q;
    end
  end

  // final clamp, and the shared-abscissa override
  always_comb begin
    pipe_res.deg = 1'b0;
    pipe_res.sat = msat_q;
    if (mneg_q) begin
      if (m_q > 48'h0000_8000_0000) begin
        pipe_res.y   = 32'h8000_0000;
        pipe_res.sat = 1'b1;
      end else begin
        pipe_res.y = ~m_q[31:0] + 32'd1;
      end
    end else begin
      if (m_q > 48'h0000_7FFF_FFFF) begin
        pipe_res.y   = 32'h7FFF_FFFF;
        pipe_res.sat = 1'b1;
      end else begin
        pipe_res.y = m_q[31:0];
      end
    end
    if (cfg.degen) begin
      pipe_res.y   = '0;
      pipe_res.sat = 1'b0;
      pipe_res.deg = 1'b1;
    end
  end

  // output word register with one skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (!skid_full_q) begin
      if (vld_q[LAT-1]) begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_full_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (!out_stall_i) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      if (vld_q[LAT-1]) begin
        if (!out_valid_q || !out_stall_i) begin
          out_q <= pipe_res;
        end else begin
          skid_q <= pipe_res;
        end
      end
    end else if (!out_stall_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign curve_y_o    = out_q.y;
  assign saturated_o  = out_q.sat;
  assign degenerate_o = out_q.deg;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_valid_q && out_stall_i && vld_q[LAT-1]))
    else $error("skid word filled without a stalled output");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (curve_y_o == 32'h0 && !saturated_o))
    else $error("degenerate word carries a value");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import qli_pkg::*;

  // index 6 has no register behind it, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd6;
  localparam logic [60:0] TERM_LIM = {61{1'b1}};

  typedef struct {
    logic [31:0] y;
    logic        sat;
    logic        deg;
  } curve_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] sample_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] curve_y;
  logic saturated;
  logic degenerate;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  quadratic_lagrange_interpolator_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_x_i(sample_x),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .curve_y_o(curve_y), .saturated_o(saturated), .degenerate_o(degenerate),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // local copy of the point registers
  logic [31:0] knot_x [3];
  logic [31:0] knot_y [3];

  logic [31:0]   sample_queue [$];
  curve_word_t   curve_queue [$];
  int errors = 0;
  int words_checked = 0;
  int sat_seen = 0;
  int deg_seen = 0;
  int phases = 0;

  // acc * num / den rounded half away from zero, clamped to the term limit
  function automatic longint scale_term(longint acc, longint num, longint den,
                                        inout bit sat);
    logic [127:0] prod, quo, rem, md;
    logic [63:0] ma, mn;
    bit neg;
    neg = ((acc < 0) != (num < 0)) != (den < 0);
    ma = (acc < 0) ? -acc : acc;
    mn = (num < 0) ? -num : num;
    md = {64'd0, ((den < 0) ? -den : den)};
    prod = {64'd0, ma} * {64'd0, mn};
    quo = prod / md;
    rem = prod % md;
    if (rem >= md - rem) quo = quo + 1;
    if (quo > {67'd0, TERM_LIM}) begin
      sat = 1'b1;
      quo = {67'd0, TERM_LIM};
    end
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic curve_word_t lagrange_eval(logic [31:0] xs);
    curve_word_t w;
    longint x, acc, sum;
    logic [63:0] m;
    bit sat;
    w.y = '0;
    w.sat = 1'b0;
    w.deg = 1'b0;
    if (knot_x[0] == knot_x[1] || knot_x[0] == knot_x[2] || knot_x[1] == knot_x[2]) begin
      w.deg = 1'b1;
      return w;
    end
    x = longint'(signed'(xs));
    sum = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(signed'(knot_y[i])) * 65536;
      for (int j = 0; j < 3; j++) begin
        if (j != i)
          acc = scale_term(acc, x - longint'(signed'(knot_x[j])),
                           longint'(signed'(knot_x[i])) - longint'(signed'(knot_x[j])), sat);
      end
      sum += acc;
    end
    m = (((sum < 0) ? -sum : sum) + 64'h8000) >> 16;
    if (sum < 0) begin
      if (m > 64'h8000_0000) begin
        m = 64'h8000_0000;
        sat = 1'b1;
      end
      w.y = -m[31:0];
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        m = 64'h7FFF_FFFF;
        sat = 1'b1;
      end
      w.y = m[31:0];
    end
    w.sat = sat;
    return w;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, words_checked);
  endtask

  // driver: bursts of random length, random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) curve_queue.push_back(lagrange_eval(sample_x));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          sample_x <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: modes of none, light and heavy back-pressure
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 4) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // monitor: compare every accepted word with the oldest prediction
  always @(posedge clk) begin
    curve_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (curve_queue.size() == 0) begin
        report("unexpected word", curve_y, 32'h0);
      end else begin
        w = curve_queue.pop_front();
        if (curve_y !== w.y) report("curve_y", curve_y, w.y);
        if (saturated !== w.sat) report("saturated", {31'd0, saturated}, {31'd0, w.sat});
        if (degenerate !== w.deg) report("degenerate", {31'd0, degenerate}, {31'd0, w.deg});
        words_checked++;
        if (w.sat) sat_seen++;
        if (w.deg) deg_seen++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_P0_X: knot_x[0] = data;
      REG_P0_Y: knot_y[0] = data;
      REG_P1_X: knot_x[1] = data;
      REG_P1_Y: knot_y[1] = data;
      REG_P2_X: knot_x[2] = data;
      REG_P2_Y: knot_y[2] = data;
      default: ;
    endcase
  endtask

  task automatic load_points(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                             logic [31:0] y1, logic [31:0] x2, logic [31:0] y2);
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_NONE, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the queue to drain and the pipe to empty
  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || curve_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    phases++;
  endtask

  function automatic logic [31:0] pick_x(int kind);
    case (kind)
      0: return $urandom;
      1: return knot_x[$urandom_range(0, 2)] + $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: return $urandom_range(0, 32'hFFF) - 32'h800;
      default: return $urandom_range(0, 32'h7FFFFF) - 32'h400000;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 32'h14_0000) - 32'h0A_0000;    // +-10.0
      1: return $urandom;
      2: return $urandom_range(0, 32'h3F) - 32'h20;              // tiny spacing
      default: return $urandom_range(0, 32'hC8_0000) - 32'h64_0000; // +-100.0
    endcase
  endfunction

  initial begin
    int mode;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    knot_x[0] = 32'h0;     knot_y[0] = 32'h0;
    knot_x[1] = 32'h10000; knot_y[1] = 32'h0;
    knot_x[2] = 32'h20000; knot_y[2] = 32'h0;
    @(posedge clk);

    // reset points: flat zero curve
    sample_queue.push_back(32'h0);
    sample_queue.push_back(32'h7FFF_FFFF);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h1);
    drain();

    // parabola y = x^2 through (0,0) (1,1) (2,4), exact at the points
    load_points(32'h0, 32'h0, 32'h10000, 32'h10000, 32'h20000, 32'h40000);
    foreach (knot_x[k]) sample_queue.push_back(knot_x[k]);
    sample_queue.push_back(32'h8000);
    sample_queue.push_back(32'hFFFF_8000);
    sample_queue.push_back(32'h7FFF_FFFF);   // overflows the final range
    sample_queue.push_back(32'h8000_0000);
    drain();

    // extreme abscissas and ordinates
    load_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h7FFF_FFFF);
    sample_queue.push_back(32'h0);
    sample_queue.push_back(32'h4000_0000);
    drain();

    // points one lsb apart, large y: term accumulators clamp
    load_points(32'h0, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 32'h2, 32'h7FFF_FFFF);
    sample_queue.push_back(32'h7FFF_FFFF);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h1);
    sample_queue.push_back(32'h3);
    drain();

    // shared abscissa, each pair in turn
    load_points(32'h5_0000, 32'h1_0000, 32'h5_0000, 32'h2_0000, 32'h9_0000, 32'h3_0000);
    sample_queue.push_back(32'h5_0000);
    sample_queue.push_back(32'h8000_0000);
    drain();
    load_points(32'h3_0000, 32'h1_0000, 32'h7_0000, 32'h2_0000, 32'h3_0000, 32'h3_0000);
    sample_queue.push_back(32'h7FFF_FFFF);
    drain();
    load_points(32'h3_0000, 32'h1_0000, 32'h8000_0000, 32'h2_0000, 32'h8000_0000, 32'h3_0000);
    sample_queue.push_back(32'h0);
    drain();

    // random phases: point sets of several shapes, samples mostly near the curve
    for (int p = 0; p < 12; p++) begin
      mode = p % 4;
      load_points(pick_coord(mode), pick_coord(mode == 2 ? 1 : mode),
                  pick_coord(mode), pick_coord(mode == 2 ? 1 : mode),
                  pick_coord(mode), pick_coord(mode == 2 ? 1 : mode));
      if (p == 7) write_reg(REG_P2_X, knot_x[0]);
      @(posedge clk);
      cfg_we <= 1'b0;
      for (int n = 0; n < 128; n++) sample_queue.push_back(pick_x($urandom_range(0, 3)));
      drain();
    end

    $display("checked %0d words over %0d point settings", words_checked, phases);
    $display("%0d words saturated, %0d with a shared abscissa", sat_seen, deg_seen);
    if (errors == 0 && curve_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", curve_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/qli_pkg.sv
rtl/core/qli_cfg.sv
rtl/core/qli_step.sv
rtl/core/quadratic_lagrange_interpolator_unit.sv
tb/sv/tb.sv
